### rtl/core/qvt_pkg.sv
package qvt_pkg;

  localparam int COORD_W    = 32;
  localparam int QPART_W    = 32;
  localparam int SHIFT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAT_N      = 9;
  localparam int N_TERMS    = 36;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z,
    REG_PLANAR
  } qvt_reg_t;

  typedef enum logic {
    MX_IDLE,
    MX_RUN
  } qvt_mx_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
    logic                      in_last;
  } qvt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      out_last;
  } qvt_out_t;

  typedef struct packed {
    logic signed [QPART_W-1:0] w;
    logic signed [QPART_W-1:0] x;
    logic signed [QPART_W-1:0] y;
    logic signed [QPART_W-1:0] z;
  } qvt_quat_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [SHIFT_W-1:0] shift_z;
    logic                      planar_mode;
  } qvt_xform_t;

  typedef logic [MAT_N-1:0][QPART_W-1:0] qvt_mat_t;

  localparam logic [QPART_W-1:0] Q_ONE  = QPART_W'(64'd1 << (QPART_W - 2));
  localparam logic [QPART_W-1:0] Q_ZERO = '0;

  localparam qvt_mat_t MAT_IDENT = {Q_ONE, Q_ZERO, Q_ZERO,
                                    Q_ZERO, Q_ONE, Q_ZERO,
                                    Q_ZERO, Q_ZERO, Q_ONE};

  localparam logic [1:0] QP_W = 2'd0;
  localparam logic [1:0] QP_X = 2'd1;
  localparam logic [1:0] QP_Y = 2'd2;
  localparam logic [1:0] QP_Z = 2'd3;

  localparam logic TERM_ADD = 1'b0;
  localparam logic TERM_SUB = 1'b1;

  typedef struct packed {
    logic       neg;
    logic [1:0] a;
    logic [1:0] b;
  } qvt_term_t;

  localparam qvt_term_t TERM_TAB [N_TERMS] = '{
    '{TERM_ADD, QP_W, QP_W}, '{TERM_ADD, QP_X, QP_X},
    '{TERM_SUB, QP_Y, QP_Y}, '{TERM_SUB, QP_Z, QP_Z},
    '{TERM_ADD, QP_X, QP_Y}, '{TERM_ADD, QP_X, QP_Y},
    '{TERM_SUB, QP_W, QP_Z}, '{TERM_SUB, QP_W, QP_Z},
    '{TERM_ADD, QP_X, QP_Z}, '{TERM_ADD, QP_X, QP_Z},
    '{TERM_ADD, QP_W, QP_Y}, '{TERM_ADD, QP_W, QP_Y},
    '{TERM_ADD, QP_X, QP_Y}, '{TERM_ADD, QP_X, QP_Y},
    '{TERM_ADD, QP_W, QP_Z}, '{TERM_ADD, QP_W, QP_Z},
    '{TERM_ADD, QP_W, QP_W}, '{TERM_SUB, QP_X, QP_X},
    '{TERM_ADD, QP_Y, QP_Y}, '{TERM_SUB, QP_Z, QP_Z},
    '{TERM_ADD, QP_Y, QP_Z}, '{TERM_ADD, QP_Y, QP_Z},
    '{TERM_SUB, QP_W, QP_X}, '{TERM_SUB, QP_W, QP_X},
    '{TERM_ADD, QP_X, QP_Z}, '{TERM_ADD, QP_X, QP_Z},
    '{TERM_SUB, QP_W, QP_Y}, '{TERM_SUB, QP_W, QP_Y},
    '{TERM_ADD, QP_Y, QP_Z}, '{TERM_ADD, QP_Y, QP_Z},
    '{TERM_ADD, QP_W, QP_X}, '{TERM_ADD, QP_W, QP_X},
    '{TERM_ADD, QP_W, QP_W}, '{TERM_SUB, QP_X, QP_X},
    '{TERM_SUB, QP_Y, QP_Y}, '{TERM_ADD, QP_Z, QP_Z}
  };

endpackage

### rtl/core/qvt_matrix.sv
module qvt_matrix
  import qvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qvt_quat_t quat,
  input  logic      restart,
  output qvt_mat_t  mat,
  output logic      busy
);

  localparam int ENT_W  = 4;
  localparam int TERM_W = 2;
  localparam int PROD_W = 2 * QPART_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC   = QPART_W - 2;
  localparam int RND_W  = ACC_W - FRAC;

  localparam logic [ENT_W-1:0]  LAST_ENT  = ENT_W'(MAT_N - 1);
  localparam logic [TERM_W-1:0] LAST_TERM = '1;
  localparam logic [ACC_W-1:0]  RND_HALF  = ACC_W'(1) << (FRAC - 1);

  qvt_mx_state_t state_r, state_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic              issue;

  qvt_term_t                term;
  logic signed [QPART_W-1:0] opa, opb;
  logic signed [PROD_W-1:0]  prod_nxt;

  logic                     prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_neg_r;
  logic                     prod_first_r;
  logic                     prod_fin_r;
  logic [ENT_W-1:0]         prod_ent_r;

  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext;
  logic                    acc_done_r;
  logic [ENT_W-1:0]        acc_ent_r;

  logic [ACC_W-1:0]   rnd_sum;
  logic [RND_W-1:0]   rnd;
  logic [QPART_W-1:0] ent_sat;

  qvt_mat_t mat_r;

  function automatic logic signed [QPART_W-1:0] quat_pick(input qvt_quat_t q,
                                                           input logic [1:0] sel);
    logic signed [QPART_W-1:0] v;
    case (sel)
      QP_W:    v = q.w;
      QP_X:    v = q.x;
      QP_Y:    v = q.y;
      QP_Z:    v = q.z;
      default: v = q.w;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
      ent_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ent_r   <= ent_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    term_nxt  = term_r;
    issue     = 1'b0;
    case (state_r)
      MX_IDLE: begin
        issue = 1'b0;
      end
      MX_RUN: begin
        issue    = 1'b1;
        term_nxt = term_r + 1'b1;
        if (term_r == LAST_TERM) begin
          ent_nxt = ent_r + 1'b1;
          if (ent_r == LAST_ENT) begin
            state_nxt = MX_IDLE;
            ent_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = MX_IDLE;
      end
    endcase
    if (restart) begin
      state_nxt = MX_RUN;
      ent_nxt   = '0;
      term_nxt  = '0;
    end
  end

  assign term     = TERM_TAB[{ent_r, term_r}];
  assign opa      = quat_pick(quat, term.a);
  assign opb      = quat_pick(quat, term.b);
  assign prod_nxt = opa * opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= issue & ~restart;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    prod_neg_r   <= term.neg;
    prod_first_r <= (term_r == '0);
    prod_fin_r   <= (term_r == LAST_TERM);
    prod_ent_r   <= ent_r;
  end

  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = (prod_first_r ? '0 : acc_r) + (prod_neg_r ? -prod_ext : prod_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_done_r <= 1'b0;
    end else begin
      acc_done_r <= prod_vld_r & prod_fin_r & ~restart;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      acc_r     <= acc_nxt;
      acc_ent_r <= prod_ent_r;
    end
  end

  assign rnd_sum = acc_r + RND_HALF;
  assign rnd     = rnd_sum[ACC_W-1:FRAC];

  always_comb begin
    if (!rnd[RND_W-1] && (|rnd[RND_W-2:QPART_W-1])) begin
      ent_sat = {1'b0, {(QPART_W-1){1'b1}}};
    end else if (rnd[RND_W-1] && !(&rnd[RND_W-2:QPART_W-1])) begin
      ent_sat = {1'b1, {(QPART_W-1){1'b0}}};
    end else begin
      ent_sat = rnd[QPART_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_IDENT;
    end else if (acc_done_r) begin
      mat_r[acc_ent_r] <= ent_sat;
    end
  end

  assign mat  = mat_r;
  assign busy = (state_r != MX_IDLE) | prod_vld_r | acc_done_r;

endmodule

### rtl/core/qvt_datapath.sv
module qvt_datapath
  import qvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qvt_mat_t   mat,
  input  qvt_xform_t xf,
  input  logic       in_vld,
  input  qvt_in_t    in_data,
  output logic       out_vld,
  output qvt_out_t   out_data
);

  localparam int CW     = COORD_W;
  localparam int MW     = QPART_W;
  localparam int FRAC_C = 16;
  localparam int HW     = CW - FRAC_C;
  localparam int PHW    = MW + HW;
  localparam int PLW    = MW + FRAC_C + 1;
  localparam int PRW    = MW + CW;
  localparam int SUMW   = PRW + 2;
  localparam int FRAC   = MW - 2;
  localparam int RW     = SUMW - FRAC;
  localparam int SW     = ((RW > SHIFT_W) ? RW : SHIFT_W) + 1;

  localparam logic [SUMW-1:0] RND_HALF = SUMW'(1) << (FRAC - 1);

  logic    s0_vld_r;
  qvt_in_t s0_data_r;
  logic signed [CW-1:0] rel [3];

  logic signed [PHW-1:0] ph_r [MAT_N];
  logic signed [PHW-1:0] ph_nxt [MAT_N];
  logic signed [PLW-1:0] pl_r [MAT_N];
  logic signed [PLW-1:0] pl_nxt [MAT_N];
  logic                  s1_vld_r, s1_last_r;
  logic signed [CW-1:0]  s1_rely_r;

  logic signed [PRW-1:0] prod_r [MAT_N];
  logic signed [PRW-1:0] prod_nxt [MAT_N];
  logic                  s2_vld_r, s2_last_r;
  logic signed [CW-1:0]  s2_rely_r;

  logic [SUMW-1:0]      sum_r [3];
  logic [SUMW-1:0]      sum_nxt [3];
  logic                 s3_vld_r, s3_last_r;
  logic signed [CW-1:0] s3_rely_r;

  logic signed [SW-1:0] res_x, res_y, res_z, base_y;

  logic     out_vld_r;
  qvt_out_t out_data_r, out_data_nxt;

  function automatic logic [CW-1:0] sat_c(input logic [SW-1:0] v);
    logic [CW-1:0] r;
    if (!v[SW-1] && (|v[SW-2:CW-1])) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v[SW-1] && !(&v[SW-2:CW-1])) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= in_vld;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      s0_data_r <= in_data;
    end
  end

  assign rel[0] = s0_data_r.rel_x;
  assign rel[1] = s0_data_r.rel_y;
  assign rel[2] = s0_data_r.rel_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ph_nxt[r*3+k] = $signed(mat[r*3+k]) * $signed(rel[k][CW-1:FRAC_C]);
        pl_nxt[r*3+k] = $signed(mat[r*3+k]) * $signed({1'b0, rel[k][FRAC_C-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_vld_r) begin
      for (int i = 0; i < MAT_N; i++) begin
        ph_r[i] <= ph_nxt[i];
        pl_r[i] <= pl_nxt[i];
      end
      s1_rely_r <= s0_data_r.rel_y;
      s1_last_r <= s0_data_r.in_last;
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      prod_nxt[i] = $signed({ph_r[i], {FRAC_C{1'b0}}}) + PRW'(pl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      for (int i = 0; i < MAT_N; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      s2_rely_r <= s1_rely_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = SUMW'(prod_r[r*3]) + SUMW'(prod_r[r*3+1]) + SUMW'(prod_r[r*3+2])
                   + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= sum_nxt[r];
      end
      s3_rely_r <= s2_rely_r;
      s3_last_r <= s2_last_r;
    end
  end

  assign base_y = xf.planar_mode ? SW'(s3_rely_r) : SW'($signed(sum_r[1][SUMW-1:FRAC]));
  assign res_x  = SW'($signed(sum_r[0][SUMW-1:FRAC])) + SW'(xf.shift_x);
  assign res_y  = base_y + SW'(xf.shift_y);
  assign res_z  = SW'($signed(sum_r[2][SUMW-1:FRAC])) + SW'(xf.shift_z);

  always_comb begin
    out_data_nxt.pos_x    = sat_c(res_x);
    out_data_nxt.pos_y    = sat_c(res_y);
    out_data_nxt.pos_z    = sat_c(res_z);
    out_data_nxt.out_last = s3_last_r;
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

### rtl/core/quaternion_vertex_transform_core.sv
// Channel   Handshake                 Payload
// input     start / busy              in_data   (qvt_in_t)
// result    out_valid (strobe)        out_data  (qvt_out_t)
// config    cfg_we                    cfg_index, cfg_wdata
//
// One vertex per cycle while busy is low; each result passes through
// the five register stages of the vertex pipeline.
// A quaternion write holds busy high while one shared
// 32x32 multiplier forms the 36 matrix terms and the entries are written.
// Reset loads the reset registers and the identity matrix and empties the pipeline.
// The receiver cannot stall; out_valid marks each result for exactly one cycle.
module quaternion_vertex_transform_core
  import qvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  qvt_in_t               in_data,
  output logic                  out_valid,
  output qvt_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  qvt_quat_t  quat_r, quat_nxt;
  qvt_xform_t xf_r, xf_nxt;
  logic       restart;
  qvt_mat_t   mat;
  logic       mx_busy;
  logic       accept;

  always_comb begin
    quat_nxt = quat_r;
    xf_nxt   = xf_r;
    restart  = 1'b0;
    if (cfg_we) begin
      case (qvt_reg_t'(cfg_index))
        REG_QUAT_W: begin
          quat_nxt.w = cfg_wdata[QPART_W-1:0];
          restart    = 1'b1;
        end
        REG_QUAT_X: begin
          quat_nxt.x = cfg_wdata[QPART_W-1:0];
          restart    = 1'b1;
        end
        REG_QUAT_Y: begin
          quat_nxt.y = cfg_wdata[QPART_W-1:0];
          restart    = 1'b1;
        end
        REG_QUAT_Z: begin
          quat_nxt.z = cfg_wdata[QPART_W-1:0];
          restart    = 1'b1;
        end
        REG_SHIFT_X: begin
          xf_nxt.shift_x = cfg_wdata[SHIFT_W-1:0];
        end
        REG_SHIFT_Y: begin
          xf_nxt.shift_y = cfg_wdata[SHIFT_W-1:0];
        end
        REG_SHIFT_Z: begin
          xf_nxt.shift_z = cfg_wdata[SHIFT_W-1:0];
        end
        REG_PLANAR: begin
          xf_nxt.planar_mode = cfg_wdata[0];
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r <= '{w: Q_ONE, x: Q_ZERO, y: Q_ZERO, z: Q_ZERO};
      xf_r   <= '0;
    end else begin
      quat_r <= quat_nxt;
      xf_r   <= xf_nxt;
    end
  end

  qvt_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .quat    (quat_r),
    .restart (restart & rst_n),
    .mat     (mat),
    .busy    (mx_busy)
  );

  assign busy   = mx_busy;
  assign accept = start & ~mx_busy;

  qvt_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .mat      (mat),
    .xf       (xf_r),
    .in_vld   (accept),
    .in_data  (in_data),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule

### rtl/core/qvt_checker.sv
module qvt_checker
  import qvt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input qvt_in_t               in_data,
  input logic                  out_valid,
  input qvt_out_t              out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  localparam int LAT = 5;

  a_quat_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_QUAT_W || cfg_index == REG_QUAT_X ||
                cfg_index == REG_QUAT_Y || cfg_index == REG_QUAT_Z)) |=> busy)
    else $error("quaternion write did not raise busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy)) |-> $past(cfg_we && !cfg_index[CFG_IDX_W-1]))
    else $error("busy rose without a quaternion write");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("transfer produced no result");

  a_last_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy, LAT) &&
                   out_data.out_last == $past(in_data.in_last, LAT)))
    else $error("result without matching transfer or last flag");

endmodule

bind quaternion_vertex_transform_core qvt_checker u_qvt_checker (.*);
